[src/bsp_pkg.sv]
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the 24-bit bitmap stream parser.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int unsigned BSP_QUEUE_DEPTH = 2;

  localparam logic [31:0] HEADER_BYTES = 32'd54;
  localparam logic [31:0] HEADER_LAST  = HEADER_BYTES - 32'd1;
  localparam logic [31:0] POS_SIZE_0   = 32'd2;
  localparam logic [31:0] POS_SIZE_1   = 32'd3;
  localparam logic [31:0] POS_SIZE_2   = 32'd4;
  localparam logic [31:0] POS_SIZE_3   = 32'd5;
  localparam logic [31:0] POS_WIDTH_0  = 32'd18;
  localparam logic [31:0] POS_WIDTH_1  = 32'd19;
  localparam logic [31:0] POS_HEIGHT_0 = 32'd22;
  localparam logic [31:0] POS_HEIGHT_1 = 32'd23;
  localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;

  // request classes handed from front to back
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_BODY   = 2'd2;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [1:0] COMP_BLUE  = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_RED   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic        restart;
    logic        start_ok;
    logic [7:0]  byte_value;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] file_size;
  } entry_t;

endpackage

[src/bsp_front.sv]
// ----------------------------------------------------------------------------
// bsp_front
// Tracks byte position, captures header fields and classifies each byte.
// ----------------------------------------------------------------------------
module bsp_front
  import bsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       start_of_file,
  output logic       q_push,
  output entry_t     q_entry
);

  logic [31:0] byte_position, byte_position_next;
  logic [31:0] size_reg, size_reg_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [31:0] pos_cur;

  always_comb begin
    pos_cur         = start_of_file ? '0 : byte_position;
    size_reg_next   = start_of_file ? '0 : size_reg;
    width_reg_next  = start_of_file ? '0 : width_reg;
    height_reg_next = start_of_file ? '0 : height_reg;
    byte_position_next = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 32'd1;
    case (pos_cur)
      POS_SIZE_0:   size_reg_next[7:0]     = byte_value;
      POS_SIZE_1:   size_reg_next[15:8]    = byte_value;
      POS_SIZE_2:   size_reg_next[23:16]   = byte_value;
      POS_SIZE_3:   size_reg_next[31:24]   = byte_value;
      POS_WIDTH_0:  width_reg_next[7:0]    = byte_value;
      POS_WIDTH_1:  width_reg_next[15:8]   = byte_value;
      POS_HEIGHT_0: height_reg_next[7:0]   = byte_value;
      POS_HEIGHT_1: height_reg_next[15:8]  = byte_value;
      default: ;
    endcase

    q_entry.restart      = start_of_file;
    q_entry.byte_value   = byte_value;
    q_entry.image_width  = width_reg_next;
    q_entry.image_height = height_reg_next;
    q_entry.file_size    = size_reg_next;
    q_entry.start_ok     = (width_reg_next != 16'd0) && (pos_cur < size_reg_next);
    if (pos_cur == HEADER_LAST) begin
      q_entry.op = OP_HEADER;
    end else if (pos_cur > HEADER_LAST) begin
      q_entry.op = OP_BODY;
    end else begin
      q_entry.op = OP_NONE;
    end
    // header bytes before the last one only need the back end when they restart it
    q_push = accept && (start_of_file || (q_entry.op != OP_NONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      size_reg      <= '0;
      width_reg     <= '0;
      height_reg    <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      size_reg      <= size_reg_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
    end
  end

endmodule

[src/bsp_queue.sv]
// ----------------------------------------------------------------------------
// bsp_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module bsp_queue
  import bsp_pkg::*;
#(
  parameter int unsigned DEPTH = BSP_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   is_full,
  output logic   is_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign is_full  = (count == CNT_FULL);
  assign is_empty = (count == '0);
  assign do_push  = push && !is_full;
  assign do_pop   = pop && !is_empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/bsp_back.sv]
// ----------------------------------------------------------------------------
// bsp_back
// Assembles pixel triples, passes header results, skips row padding and holds the result register.
// ----------------------------------------------------------------------------
module bsp_back
  import bsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  entry_t      q_entry,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic        kind,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [31:0] file_size
);

  logic [1:0]  component_index, component_index_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [1:0]  padding_left, padding_left_next;
  logic [16:0] column_inc;
  logic        out_valid;
  logic        emit;

  assign empty = !out_valid;
  assign q_pop = !q_empty && (!out_valid || pop);

  always_comb begin
    component_index_next = q_entry.restart ? COMP_BLUE : component_index;
    held_blue_next       = q_entry.restart ? '0 : held_blue;
    held_green_next      = q_entry.restart ? '0 : held_green;
    column_count_next    = q_entry.restart ? '0 : column_count;
    row_count_next       = q_entry.restart ? '0 : row_count;
    padding_left_next    = q_entry.restart ? '0 : padding_left;
    column_inc           = {1'b0, column_count_next} + 17'd1;
    emit                 = 1'b0;
    case (q_entry.op)
      OP_HEADER: emit = 1'b1;
      OP_BODY: begin
        if (padding_left_next != 2'd0) begin
          padding_left_next = padding_left_next - 2'd1;
        end else if (component_index_next == COMP_BLUE) begin
          if (q_entry.start_ok) begin
            held_blue_next       = q_entry.byte_value;
            component_index_next = COMP_GREEN;
          end
        end else if (component_index_next == COMP_GREEN) begin
          held_green_next      = q_entry.byte_value;
          component_index_next = COMP_RED;
        end else begin
          emit                 = 1'b1;
          component_index_next = COMP_BLUE;
          // end of a stored row wraps the column and arms the padding skip
          if (column_inc >= {1'b0, q_entry.image_width}) begin
            column_count_next = '0;
            row_count_next    = row_count_next + 16'd1;
            padding_left_next = q_entry.image_width[1:0];
          end else begin
            column_count_next = column_inc[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      component_index <= COMP_BLUE;
      held_blue       <= '0;
      held_green      <= '0;
      column_count    <= '0;
      row_count       <= '0;
      padding_left    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (q_pop) begin
        component_index <= component_index_next;
        held_blue       <= held_blue_next;
        held_green      <= held_green_next;
        column_count    <= column_count_next;
        row_count       <= row_count_next;
        padding_left    <= padding_left_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      image_width  <= q_entry.image_width;
      image_height <= q_entry.image_height;
      file_size    <= q_entry.file_size;
      if (q_entry.op == OP_HEADER) begin
        kind   <= KIND_HEADER;
        blue   <= '0;
        green  <= '0;
        red    <= '0;
        column <= '0;
        row    <= '0;
      end else begin
        kind   <= KIND_PIXEL;
        blue   <= held_blue_next;
        green  <= held_green_next;
        red    <= q_entry.byte_value;
        column <= q_entry.restart ? '0 : column_count;
        row    <= q_entry.restart ? '0 : row_count;
      end
    end
  end

endmodule

[src/bmp24_stream_pixel_parser_unit.sv]
// ----------------------------------------------------------------------------
// bmp24_stream_pixel_parser_unit
// Byte-stream parser for 24-bit bitmap files: header summary and pixels.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while full is low and gives at most one result
// per byte: a header result after byte 53, then one pixel result per B,G,R
// triple with its column and row, skipping width mod 4 padding bytes after
// each row. A byte with start_of_file high restarts the parse. The front end
// counts position and captures header fields as each byte is accepted; a
// QUEUE_DEPTH-entry request queue feeds the back end, which assembles triples
// into a one-entry result register. Sustained rate is one byte per cycle while
// results are popped as they appear; a result reaches the result ports through
// the request queue and the result register. While a result waits unpopped
// the back end stalls, and full rises once QUEUE_DEPTH requests are queued.
module bmp24_stream_pixel_parser_unit
  import bsp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = BSP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_value,
  input  logic        start_of_file,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [31:0] file_size
);

  logic   accept;
  logic   q_push, q_pop, q_empty;
  entry_t wr_entry, rd_entry;

  assign accept = push && !full;

  bsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_value    (byte_value),
    .start_of_file (start_of_file),
    .q_push        (q_push),
    .q_entry       (wr_entry)
  );

  bsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .is_full  (full),
    .is_empty (q_empty)
  );

  bsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_entry      (rd_entry),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .column       (column),
    .row          (row),
    .image_width  (image_width),
    .image_height (image_height),
    .file_size    (file_size)
  );

endmodule

[test/tb_bmp24_stream_pixel_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp24_stream_pixel_parser_unit
// Self-checking bench for the 24-bit bitmap byte-stream parser.
// ----------------------------------------------------------------------------
// Feeds whole bitmap files, truncated files and loose noise bytes one byte per
// request. Every result is compared with a cycle-free model of the parser held
// in this bench. A short table of hand-picked files comes first: no start flag
// after reset, zero width, tiny and huge file sizes, every padding amount and
// restarts in the header and inside a triple. Random files follow. Both sides
// idle at random, the result side backs off for a long stretch once, and the
// feeding side drains the parser now and then.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_pixel_parser_unit
  import bsp_pkg::*;
();

  typedef struct packed {
    logic        kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] file_size;
  } pix_result_t;

  // one file to stream: header fields, body length, fill byte and where to cut
  typedef struct packed {
    bit          sof;
    logic [31:0] size;
    logic [15:0] width;
    logic [15:0] height;
    int          body;
    int          fill;
    bit          given;
    int          sent;
  } bmp_file_t;

  localparam int FILL_RANDOM    = -1;
  localparam int RANDOM_BYTES   = 1080;
  localparam int IDLE_PCT       = 26;
  localparam int QUIET_FROM     = 1500;
  localparam int QUIET_TO       = 2300;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIRECTED   = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  byte_value = 8'd0;
  logic        start_of_file = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic        kind;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [15:0] column;
  logic [15:0] row;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [31:0] file_size;

  bmp24_stream_pixel_parser_unit i_dut (
    .clk, .rst, .push, .full, .byte_value, .start_of_file, .empty, .pop,
    .kind, .blue, .green, .red, .column, .row, .image_width, .image_height,
    .file_size
  );

  always #5 clk = ~clk;

  // parser model state
  logic [31:0] pos_q = '0;
  logic [31:0] fsize_q = '0;
  logic [15:0] width_q = '0;
  logic [15:0] height_q = '0;
  logic [7:0]  blue_q = '0;
  logic [7:0]  green_q = '0;
  logic [1:0]  comp_q = COMP_BLUE;
  logic [15:0] col_q = '0;
  logic [15:0] row_q = '0;
  logic [1:0]  pad_q = '0;

  pix_result_t pending_results [$];
  pix_result_t hdr_override;
  bit          hdr_override_on = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          n_fail = 0;
  int          n_headers = 0;
  int          n_pixels = 0;
  int          n_files = 0;
  int          bytes_sent = 0;
  int          cyc = 0;
  int          quiet_cycles = 0;

  bmp_file_t directed_files [NUM_DIRECTED] = '{
    // no start flag after reset, width 1 with one pad byte, bytes past size
    '{1'b0, 32'd58, 16'd1, 16'd1, 8, FILL_RANDOM, 1'b1, 0},
    // width 2, two pad bytes per row
    '{1'b1, 32'd70, 16'd2, 16'd2, 20, FILL_RANDOM, 1'b1, 0},
    // last triple starts one byte below size and still completes
    '{1'b1, 32'd55, 16'd3, 16'd1, 6, FILL_RANDOM, 1'b1, 0},
    // zero width: body ignored
    '{1'b1, 32'd1000, 16'd0, 16'd5, 30, FILL_RANDOM, 1'b1, 0},
    // size below header length
    '{1'b1, 32'd10, 16'd4, 16'd4, 20, FILL_RANDOM, 1'b1, 0},
    // all ones everywhere
    '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 30, 255, 1'b1, 0},
    // all zeros everywhere
    '{1'b1, 32'd0, 16'd0, 16'd0, 6, 0, 1'b1, 0},
    // width 5, one pad byte
    '{1'b1, 32'd200, 16'd5, 16'd3, 60, FILL_RANDOM, 1'b1, 0},
    // cut after the blue byte of a triple, then restart
    '{1'b1, 32'd200, 16'd4, 16'd2, 30, FILL_RANDOM, 1'b0, 64},
    // restart in the middle of the header
    '{1'b1, 32'd300, 16'd3, 16'd3, 0, FILL_RANDOM, 1'b0, 20},
    // no start flag: bytes carry on the cut header above
    '{1'b0, 32'd300, 16'd7, 16'd2, 20, FILL_RANDOM, 1'b0, 0},
    // width 6, two pad bytes, rows past height
    '{1'b1, 32'd400, 16'd6, 16'd2, 45, FILL_RANDOM, 1'b1, 0}
  };

  function automatic bit idle_now();
    return (cyc < QUIET_FROM || cyc >= QUIET_TO) && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic sof,
                                    output pix_result_t res);
    logic [31:0] p;
    bit          hit;
    if (sof) begin
      pos_q = '0; fsize_q = '0; width_q = '0; height_q = '0;
      blue_q = '0; green_q = '0; comp_q = COMP_BLUE;
      col_q = '0; row_q = '0; pad_q = '0;
    end
    p = pos_q;
    if (pos_q != POS_MAX) pos_q = pos_q + 32'd1;
    hit = 1'b0;
    res = '0;
    if (p < HEADER_BYTES) begin
      case (p)
        POS_SIZE_0:   fsize_q[7:0] = b;
        POS_SIZE_1:   fsize_q[15:8] = b;
        POS_SIZE_2:   fsize_q[23:16] = b;
        POS_SIZE_3:   fsize_q[31:24] = b;
        POS_WIDTH_0:  width_q[7:0] = b;
        POS_WIDTH_1:  width_q[15:8] = b;
        POS_HEIGHT_0: height_q[7:0] = b;
        POS_HEIGHT_1: height_q[15:8] = b;
        default: ;
      endcase
      if (p == HEADER_LAST) begin
        res.kind = KIND_HEADER;
        hit = 1'b1;
      end
    end else if (pad_q != 2'd0) begin
      pad_q = pad_q - 2'd1;
    end else if (comp_q == COMP_BLUE) begin
      if (width_q != 16'd0 && p < fsize_q) begin
        blue_q = b;
        comp_q = COMP_GREEN;
      end
    end else if (comp_q == COMP_GREEN) begin
      green_q = b;
      comp_q = COMP_RED;
    end else begin
      res.kind = KIND_PIXEL;
      res.blue = blue_q;
      res.green = green_q;
      res.red = b;
      res.column = col_q;
      res.row = row_q;
      hit = 1'b1;
      comp_q = COMP_BLUE;
      col_q = col_q + 16'd1;
      if (col_q >= width_q) begin
        col_q = '0;
        row_q = row_q + 16'd1;
        pad_q = width_q[1:0];
      end
    end
    res.image_width = width_q;
    res.image_height = height_q;
    res.file_size = fsize_q;
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // input side model update first, then result check, all on sampled values
  always @(posedge clk) begin
    pix_result_t exp_r;
    pix_result_t got_r;
    if (!rst) begin
      if (push && !full) begin
        if (parse_byte(byte_value, start_of_file, exp_r)) begin
          if (hdr_override_on && exp_r.kind == KIND_HEADER) exp_r = hdr_override;
          pending_results.push_back(exp_r);
        end
      end
      if (pop && !empty) begin
        got_r = {kind, blue, green, red, column, row, image_width, image_height,
                 file_size};
        if (pending_results.size() == 0) begin
          $error("result with no request pending: kind %0d", kind);
          n_fail++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("kind", 32'(exp_r.kind), 32'(got_r.kind));
          check_field("blue", 32'(exp_r.blue), 32'(got_r.blue));
          check_field("green", 32'(exp_r.green), 32'(got_r.green));
          check_field("red", 32'(exp_r.red), 32'(got_r.red));
          check_field("column", 32'(exp_r.column), 32'(got_r.column));
          check_field("row", 32'(exp_r.row), 32'(got_r.row));
          check_field("image_width", 32'(exp_r.image_width),
                      32'(got_r.image_width));
          check_field("image_height", 32'(exp_r.image_height),
                      32'(got_r.image_height));
          check_field("file_size", exp_r.file_size, got_r.file_size);
          if (exp_r.kind == KIND_HEADER) n_headers++;
          else n_pixels++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random pops, one long back-off once asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop <= !idle_now();
    end
  end

  // call and return at a falling edge; push stays high into the next byte
  task automatic send_byte(input logic [7:0] b, input logic sof);
    while (idle_now()) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    byte_value <= b;
    start_of_file <= sof;
    do @(posedge clk); while (full);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pause();
    push <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] file_byte(input bmp_file_t f, input int i);
    logic [31:0] p;
    p = i;
    case (p)
      POS_SIZE_0:   return f.size[7:0];
      POS_SIZE_1:   return f.size[15:8];
      POS_SIZE_2:   return f.size[23:16];
      POS_SIZE_3:   return f.size[31:24];
      POS_WIDTH_0:  return f.width[7:0];
      POS_WIDTH_1:  return f.width[15:8];
      POS_HEIGHT_0: return f.height[7:0];
      POS_HEIGHT_1: return f.height[15:8];
      default:      return (f.fill < 0) ? 8'($urandom_range(255)) : f.fill[7:0];
    endcase
  endfunction

  task automatic send_file(input bmp_file_t f);
    int total;
    total = (f.sent != 0) ? f.sent : int'(HEADER_BYTES) + f.body;
    hdr_override = '0;
    hdr_override.kind = KIND_HEADER;
    hdr_override.image_width = f.width;
    hdr_override.image_height = f.height;
    hdr_override.file_size = f.size;
    hdr_override_on = f.given;
    for (int i = 0; i < total; i++) send_byte(file_byte(f, i), f.sof && i == 0);
    n_files++;
  endtask

  // mostly consistent files with random pixels, some with wild header fields
  function automatic bmp_file_t random_file(input bit wild);
    bmp_file_t f;
    int        w;
    int        span;
    f = '0;
    f.fill = FILL_RANDOM;
    if (wild) begin
      f.sof = ($urandom_range(2) != 0);
      f.size = $urandom();
      f.width = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom_range(65535));
      f.height = 16'($urandom_range(65535));
      f.body = $urandom_range(40);
    end else begin
      f.sof = 1'b1;
      w = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 9);
      f.width = 16'(w);
      f.height = 16'($urandom_range(1, 4));
      span = int'(f.height) * (3 * w + w % 4);
      if (span > 150) span = $urandom_range(30, 150);
      f.size = int'(HEADER_BYTES) + span;
      if ($urandom_range(3) == 0) f.size = f.size + $urandom_range(8) - 4;
      f.body = span + $urandom_range(6);
    end
    if ($urandom_range(9) == 0) f.sent = $urandom_range(1, int'(HEADER_LAST) + f.body);
    return f;
  endfunction

  initial begin
    int dir_bytes;
    int pick;
    int n;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_files[k]) send_file(directed_files[k]);
    dir_bytes = bytes_sent;
    hdr_override_on = 1'b0;
    drain_pause();

    hold_req = 1'b1;
    while (bytes_sent < dir_bytes + RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // loose noise, now and then restarting the parse
        n = $urandom_range(1, 30);
        repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
      end else begin
        send_file(random_file(pick < 20));
      end
      if ($urandom_range(5) == 0) drain_pause();
    end
    drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("streamed %0d bytes in %0d files plus noise (%0d in the directed part)",
             bytes_sent, n_files, dir_bytes);
    $display("checked %0d header and %0d pixel results", n_headers, n_pixels);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
